FILE: hdl/psrf_pkg.sv
// ----------------------------------------------------------------------------
// psrf_pkg
// shared types, constants and saturation helpers of the secant root finder
// ----------------------------------------------------------------------------
package psrf_pkg;

  localparam int unsigned MAX_DEGREE_DEF     = 8;
  localparam int unsigned MAX_ITERATIONS_DEF = 64;
  localparam int unsigned FRACTION_BITS_DEF  = 16;

  // bracket tests allowed per search
  localparam int unsigned MaxScanPoints = 1048576;
  localparam int unsigned ScanCntW      = $clog2(MaxScanPoints + 1);

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_CONVERGED  = 2'd0;
  localparam status_t ST_ITER_LIMIT = 2'd1;
  localparam status_t ST_ZERO_DEN   = 2'd2;
  localparam status_t ST_SCAN_DONE  = 2'd3;

  // register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DEGREE    = 2'd0;
  localparam cfg_idx_t CFG_SCAN_STEP = 2'd1;
  localparam cfg_idx_t CFG_TOLERANCE = 2'd2;

  localparam logic [3:0]  DEGREE_RST    = 4'd2;
  localparam logic [30:0] SCAN_STEP_RST = 31'd29491;
  localparam logic [30:0] TOLERANCE_RST = 31'd66;

  // request and response of a shared arithmetic unit
  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } op_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] result;
  } op_rsp_t;

  function automatic logic signed [35:0] sext36(input logic signed [31:0] v);
    return 36'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < 36'shF80000000) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: hdl/psrf_mul.sv
// ----------------------------------------------------------------------------
// psrf_mul
// fixed-point multiplier, round half away from zero, saturating
// ----------------------------------------------------------------------------
module psrf_mul #(
  parameter int unsigned FRACTION_BITS = psrf_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psrf_pkg::op_req_t req_i,
  output psrf_pkg::op_rsp_t rsp_o
);

  localparam logic [63:0] Half = 64'd1 << (FRACTION_BITS - 1);

  logic [31:0]        ma_q, mb_q;
  logic               neg1_q, neg2_q;
  logic [63:0]        prod_q;
  logic [63:0]        rnd;
  logic signed [31:0] res_d, res_q;
  logic [2:0]         vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], req_i.start};
    end
  end

  // stage 1 magnitudes, stage 2 product, stage 3 rounding
  always_ff @(posedge clk_i) begin
    ma_q   <= req_i.a[31] ? (~req_i.a + 32'd1) : req_i.a;
    mb_q   <= req_i.b[31] ? (~req_i.b + 32'd1) : req_i.b;
    neg1_q <= req_i.a[31] ^ req_i.b[31];
    prod_q <= 64'(ma_q) * 64'(mb_q);
    neg2_q <= neg1_q;
    res_q  <= res_d;
  end

  always_comb begin
    rnd = (prod_q + Half) >> FRACTION_BITS;
    if (neg2_q) begin
      res_d = (rnd >= 64'h80000000) ? 32'sh80000000 : -$signed(rnd[31:0]);
    end else begin
      res_d = (rnd >= 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(rnd[31:0]);
    end
  end

  assign rsp_o.done   = vld_q[2];
  assign rsp_o.result = res_q;

endmodule

FILE: hdl/psrf_div.sv
// ----------------------------------------------------------------------------
// psrf_div
// fixed-point divider, restoring, one quotient bit a cycle, saturating
// ----------------------------------------------------------------------------
module psrf_div #(
  parameter int unsigned FRACTION_BITS = psrf_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psrf_pkg::op_req_t req_i,
  output psrf_pkg::op_rsp_t rsp_o
);

  localparam int unsigned DW = 33 + FRACTION_BITS;
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q, quo_q, quo_d;
  logic [31:0]   rem_q, nb_q, na, nb;
  logic [32:0]   rem2;
  logic          ge, neg_q;
  logic signed [31:0] res_q, res_d;

  assign na   = req_i.a[31] ? (~req_i.a + 32'd1) : req_i.a;
  assign nb   = req_i.b[31] ? (~req_i.b + 32'd1) : req_i.b;
  assign rem2 = {rem_q, dvd_q[DW-1]};
  assign ge   = rem2 >= {1'b0, nb_q};
  assign quo_d = {quo_q[DW-2:0], ge};

  always_comb begin
    if (neg_q) begin
      res_d = (quo_d >= DW'(64'h80000000)) ? 32'sh80000000 : -$signed(quo_d[31:0]);
    end else begin
      res_d = (quo_d >= DW'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(quo_d[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= (DW'(na) << FRACTION_BITS) + DW'(nb >> 1);
      nb_q  <= nb;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= req_i.a[31] ^ req_i.b[31];
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? 32'(rem2 - {1'b0, nb_q}) : rem2[31:0];
      quo_q <= quo_d;
      if (cnt_q == CW'(1)) begin
        res_q <= res_d;
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

FILE: hdl/polynomial_secant_root_finder.sv
// ----------------------------------------------------------------------------
// polynomial_secant_root_finder
// bracket scan and secant search for real roots of a Q16.16 polynomial
// ----------------------------------------------------------------------------
// search: after the last coefficient the search evaluates the polynomial by
//   Horner steps on the shared multiplier and takes each quotient from the
//   shared divider
// throughput: one item at a time; the input stays not ready for the search
// reset: asynchronous, active low; registers return to degree 2, step 0.45,
//   tolerance 0.001; the coefficient store needs no clearing
module polynomial_secant_root_finder #(
  parameter int unsigned MAX_DEGREE     = psrf_pkg::MAX_DEGREE_DEF,
  parameter int unsigned MAX_ITERATIONS = psrf_pkg::MAX_ITERATIONS_DEF,
  parameter int unsigned FRACTION_BITS  = psrf_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // coefficient stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] coefficient
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] root_value, [35:32] root_number, zero pad
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,   // last_result
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IW  = $clog2(MAX_DEGREE + 1);   // store index
  localparam int unsigned LCW = $clog2(MAX_DEGREE + 2);   // load count
  localparam int unsigned ITW = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned SPW = psrf_pkg::ScanCntW;
  localparam logic signed [35:0] QOne = 36'sd1 <<< FRACTION_BITS;

  // sequencer states
  localparam logic [4:0] S_LOAD      = 5'd0;
  localparam logic [4:0] S_START     = 5'd1;
  localparam logic [4:0] S_LIM_START = 5'd2;
  localparam logic [4:0] S_LIM_WAIT  = 5'd3;
  localparam logic [4:0] S_SCAN_INIT = 5'd4;
  localparam logic [4:0] S_SCAN_TEST = 5'd5;
  localparam logic [4:0] S_SCAN_FL   = 5'd6;
  localparam logic [4:0] S_SCAN_FR   = 5'd7;
  localparam logic [4:0] S_SEC_TOP   = 5'd8;
  localparam logic [4:0] S_SEC_F0    = 5'd9;
  localparam logic [4:0] S_SEC_F1    = 5'd10;
  localparam logic [4:0] S_SEC_DIV   = 5'd11;
  localparam logic [4:0] S_SEC_MUL   = 5'd12;
  localparam logic [4:0] S_SEC_CHK   = 5'd13;
  localparam logic [4:0] S_ROOT      = 5'd14;
  localparam logic [4:0] S_FINISH    = 5'd15;
  localparam logic [4:0] S_H_MUL     = 5'd16;
  localparam logic [4:0] S_H_WAIT    = 5'd17;

  // configuration
  logic [3:0]  degree_q;
  logic [30:0] step_q, tol_q, step_eff;
  logic [IW-1:0] eff_deg;

  // state
  logic [4:0]  state_q, state_d, ret_q, ret_d;
  logic [LCW-1:0] load_cnt_q, load_cnt_d, idx_q, idx_d;
  logic signed [31:0] store_q [MAX_DEGREE+1];
  logic signed [31:0] rd_coef;
  logic signed [31:0] lim_q, lim_d, left_q, left_d;
  logic signed [33:0] right_q, right_d;
  logic signed [31:0] prev_q, prev_d, curr_q, curr_d;
  logic signed [31:0] fl_q, fl_d, f0_q, f0_d;
  logic signed [31:0] h_x_q, h_x_d, h_acc_q, h_acc_d;
  logic [ITW-1:0] iter_q, iter_d;
  logic [SPW-1:0] points_q, points_d;
  logic [IW-1:0]  roots_q, roots_d;
  psrf_pkg::status_t st_q, st_d;

  // output register
  logic               out_vld_q, out_vld_d, out_free;
  logic signed [31:0] out_val_q, out_val_d;
  logic [3:0]         out_num_q, out_num_d;
  psrf_pkg::status_t  out_st_q, out_st_d;
  logic               out_last_q, out_last_d;

  // shared units
  psrf_pkg::op_req_t mul_req, div_req;
  psrf_pkg::op_rsp_t mul_rsp, div_rsp;

  // scratch
  logic signed [31:0] abs_r, lim_n, left_n, nx, dsec, dnum;
  logic signed [32:0] nx_diff;
  logic [32:0]        nx_mag, acc_mag;
  logic               in_xfer;

  assign eff_deg  = (degree_q == 4'd0) ? IW'(1) :
                    (32'(degree_q) > MAX_DEGREE) ? IW'(MAX_DEGREE) : IW'(degree_q);
  assign step_eff = (step_q == 31'd0) ? 31'd1 : step_q;
  assign rd_coef  = store_q[idx_q[IW-1:0]];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_LOAD);
  assign cfg_ready_o   = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= psrf_pkg::DEGREE_RST;
      step_q   <= psrf_pkg::SCAN_STEP_RST;
      tol_q    <= psrf_pkg::TOLERANCE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psrf_pkg::CFG_DEGREE:    degree_q <= cfg_data_i[3:0];
        psrf_pkg::CFG_SCAN_STEP: step_q   <= cfg_data_i[30:0];
        psrf_pkg::CFG_TOLERANCE: tol_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // coefficient store, written in load order
  always_ff @(posedge clk_i) begin
    if (in_xfer && (32'(load_cnt_q) <= MAX_DEGREE)) begin
      store_q[load_cnt_q[IW-1:0]] <= $signed(s_axis_tdata);
    end
  end

  psrf_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp)
  );

  psrf_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  // arithmetic shared by several states
  always_comb begin
    abs_r   = (div_rsp.result == 32'sh80000000) ? 32'sh7FFFFFFF :
              (div_rsp.result < 0) ? -div_rsp.result : div_rsp.result;
    lim_n   = psrf_pkg::sat32(psrf_pkg::sext36(lim_q) + QOne);
    left_n  = psrf_pkg::sat32(psrf_pkg::sext36(curr_q) + 36'(step_eff));
    dsec    = psrf_pkg::sat32(psrf_pkg::sext36(curr_q) - psrf_pkg::sext36(prev_q));
    dnum    = psrf_pkg::sat32(psrf_pkg::sext36(h_acc_q) - psrf_pkg::sext36(f0_q));
    nx      = psrf_pkg::sat32(psrf_pkg::sext36(curr_q) - psrf_pkg::sext36(mul_rsp.result));
    nx_diff = 33'(nx) - 33'(curr_q);
    nx_mag  = nx_diff[32] ? 33'(-nx_diff) : 33'(nx_diff);
    acc_mag = h_acc_q[31] ? (33'd0 - 33'(h_acc_q)) : 33'(h_acc_q);
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    load_cnt_d = load_cnt_q;
    idx_d      = idx_q;
    lim_d      = lim_q;
    left_d     = left_q;
    right_d    = right_q;
    prev_d     = prev_q;
    curr_d     = curr_q;
    fl_d       = fl_q;
    f0_d       = f0_q;
    h_x_d      = h_x_q;
    h_acc_d    = h_acc_q;
    iter_d     = iter_q;
    points_d   = points_q;
    roots_d    = roots_q;
    st_d       = st_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_val_d  = out_val_q;
    out_num_d  = out_num_q;
    out_st_d   = out_st_q;
    out_last_d = out_last_q;
    mul_req    = '{start: 1'b0, a: h_acc_q, b: h_x_q};
    div_req    = '{start: 1'b0, a: rd_coef, b: store_q[0]};

    unique case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          load_cnt_d = load_cnt_q + 1'b1;
          if (load_cnt_d >= LCW'(eff_deg) + 1'b1) begin
            load_cnt_d = '0;
            roots_d    = '0;
            state_d    = S_START;
          end
        end
      end
      S_START: begin
        lim_d = 32'(QOne);
        idx_d = '0;
        state_d = (store_q[0] == 32'sd0) ? S_FINISH : S_LIM_START;
      end
      // search limit: max |a_i / a_0| over all coefficients
      S_LIM_START: begin
        div_req.start = 1'b1;
        state_d = S_LIM_WAIT;
      end
      S_LIM_WAIT: begin
        if (div_rsp.done) begin
          if (abs_r > lim_q) lim_d = abs_r;
          idx_d = idx_q + 1'b1;
          state_d = (idx_q == LCW'(eff_deg)) ? S_SCAN_INIT : S_LIM_START;
        end
      end
      S_SCAN_INIT: begin
        lim_d    = lim_n;
        left_d   = -lim_n;
        right_d  = 34'(-lim_n) + 34'(step_eff);
        points_d = '0;
        state_d  = S_SCAN_TEST;
      end
      S_SCAN_TEST: begin
        if (right_q <= 34'(lim_q) && points_q < SPW'(psrf_pkg::MaxScanPoints) &&
            roots_q < eff_deg) begin
          points_d = points_q + 1'b1;
          h_x_d = left_q; h_acc_d = store_q[0]; idx_d = LCW'(1);
          ret_d = S_SCAN_FL; state_d = S_H_MUL;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN_FL: begin
        fl_d = h_acc_q;
        h_x_d = right_q[31:0]; h_acc_d = store_q[0]; idx_d = LCW'(1);
        ret_d = S_SCAN_FR; state_d = S_H_MUL;
      end
      S_SCAN_FR: begin
        if ((fl_q < 0 && h_acc_q > 0) || (fl_q > 0 && h_acc_q < 0)) begin
          prev_d  = left_q;
          curr_d  = right_q[31:0];
          iter_d  = '0;
          state_d = S_SEC_TOP;
        end else begin
          right_d = right_q + 34'(step_eff);
          state_d = S_SCAN_TEST;
        end
      end
      // secant iteration
      S_SEC_TOP: begin
        if (iter_q >= ITW'(MAX_ITERATIONS)) begin
          st_d = psrf_pkg::ST_ITER_LIMIT;
          state_d = S_ROOT;
        end else begin
          h_x_d = prev_q; h_acc_d = store_q[0]; idx_d = LCW'(1);
          ret_d = S_SEC_F0; state_d = S_H_MUL;
        end
      end
      S_SEC_F0: begin
        f0_d = h_acc_q;
        h_x_d = curr_q; h_acc_d = store_q[0]; idx_d = LCW'(1);
        ret_d = S_SEC_F1; state_d = S_H_MUL;
      end
      S_SEC_F1: begin
        if (f0_q == h_acc_q) begin
          st_d = psrf_pkg::ST_ZERO_DEN;
          state_d = S_ROOT;
        end else begin
          div_req = '{start: 1'b1, a: h_acc_q, b: dnum};
          state_d = S_SEC_DIV;
        end
      end
      S_SEC_DIV: begin
        if (div_rsp.done) begin
          mul_req = '{start: 1'b1, a: div_rsp.result, b: dsec};
          state_d = S_SEC_MUL;
        end
      end
      S_SEC_MUL: begin
        if (mul_rsp.done) begin
          iter_d = iter_q + 1'b1;
          prev_d = curr_q;
          curr_d = nx;
          if (nx_mag < 33'(tol_q)) begin
            h_x_d = nx; h_acc_d = store_q[0]; idx_d = LCW'(1);
            ret_d = S_SEC_CHK; state_d = S_H_MUL;
          end else begin
            state_d = S_SEC_TOP;
          end
        end
      end
      S_SEC_CHK: begin
        if (acc_mag < 33'(tol_q)) begin
          st_d = psrf_pkg::ST_CONVERGED;
          state_d = S_ROOT;
        end else begin
          state_d = S_SEC_TOP;
        end
      end
      S_ROOT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_val_d  = curr_q;
          out_num_d  = 4'(roots_q + 1'b1);
          out_st_d   = st_q;
          out_last_d = 1'b0;
          roots_d    = roots_q + 1'b1;
          left_d     = left_n;
          right_d    = 34'(left_n) + 34'(step_eff);
          state_d    = S_SCAN_TEST;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_val_d  = '0;
          out_num_d  = 4'(roots_q);
          out_st_d   = psrf_pkg::ST_SCAN_DONE;
          out_last_d = 1'b1;
          state_d    = S_LOAD;
        end
      end
      // Horner step: acc = sat(acc * x + a_i)
      S_H_MUL: begin
        mul_req.start = 1'b1;
        state_d = S_H_WAIT;
      end
      S_H_WAIT: begin
        if (mul_rsp.done) begin
          h_acc_d = psrf_pkg::sat32(psrf_pkg::sext36(mul_rsp.result) +
                                    psrf_pkg::sext36(rd_coef));
          idx_d = idx_q + 1'b1;
          state_d = (idx_q == LCW'(eff_deg)) ? ret_q : S_H_MUL;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      ret_q      <= S_LOAD;
      load_cnt_q <= '0;
      idx_q      <= '0;
      iter_q     <= '0;
      points_q   <= '0;
      roots_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      load_cnt_q <= load_cnt_d;
      idx_q      <= idx_d;
      iter_q     <= iter_d;
      points_q   <= points_d;
      roots_q    <= roots_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q      <= lim_d;
    left_q     <= left_d;
    right_q    <= right_d;
    prev_q     <= prev_d;
    curr_q     <= curr_d;
    fl_q       <= fl_d;
    f0_q       <= f0_d;
    h_x_q      <= h_x_d;
    h_acc_q    <= h_acc_d;
    st_q       <= st_d;
    out_val_q  <= out_val_d;
    out_num_q  <= out_num_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_num_q, out_val_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == psrf_pkg::ST_SCAN_DONE)
    else $error("final result without scan-finished status");

  a_root_numbered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[35:32] != 4'd0)
    else $error("root result with zero ordinal");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_LIM_WAIT || state_q == S_SEC_DIV))
    else $error("divider finished outside a waiting state");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(iter_q) <= MAX_ITERATIONS)
    else $error("iteration count past the limit");
`endif

endmodule

FILE: dv/tb_polynomial_secant_root_finder.sv
// ----------------------------------------------------------------------------
// tb_polynomial_secant_root_finder
// self-checking bench: coefficient loads in, predicted root stream compared
// field by field, under changing registers and random backpressure
// ----------------------------------------------------------------------------
module tb_polynomial_secant_root_finder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDeg   = psrf_pkg::MAX_DEGREE_DEF;
  localparam int unsigned MaxIter  = psrf_pkg::MAX_ITERATIONS_DEF;
  localparam int unsigned FracBits = psrf_pkg::FRACTION_BITS_DEF;
  localparam longint      QOne     = longint'(1) << FracBits;
  localparam longint      S32Max   = 64'sd2147483647;
  localparam longint      S32Min   = -64'sd2147483648;
  localparam int          IdleLimit = 4000000;

  typedef struct {
    logic [31:0]       root;
    logic [3:0]        num;
    psrf_pkg::status_t st;
    logic              last;
  } root_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  psrf_pkg::cfg_idx_t cfg_index_i = psrf_pkg::CFG_DEGREE;
  logic [31:0] cfg_data_i = '0;

  // pending coefficients and expected roots
  logic [31:0] coef_q[$];
  root_rec_t   root_q[$];
  int          fail_cnt = 0;
  int          idle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // register copy of the predictor
  logic [3:0]  deg_reg = psrf_pkg::DEGREE_RST;
  logic [30:0] step_reg = psrf_pkg::SCAN_STEP_RST;
  logic [30:0] tol_reg = psrf_pkg::TOLERANCE_RST;

  // predictor state
  longint      cstore[MaxDeg+1];
  int unsigned load_cnt = 0;
  int unsigned eff_deg;

  polynomial_secant_root_finder dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint sat(longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint from_magn(longint unsigned m, bit neg);
    if (m > (64'd1 << 32)) m = 64'd1 << 32;
    return sat(neg ? -longint'(m) : longint'(m));
  endfunction

  // rounded fixed-point product, ties away from zero
  function automatic longint fx_mul(longint a, longint b);
    longint unsigned m;
    m = magn(a) * magn(b);
    m = (m + (64'd1 << (FracBits - 1))) >> FracBits;
    return from_magn(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    longint unsigned mb, m;
    mb = magn(b);
    m = ((magn(a) << FracBits) + mb / 2) / mb;
    return from_magn(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint poly_at(longint x);
    longint acc;
    acc = cstore[0];
    for (int i = 1; i <= eff_deg; i++) acc = sat(fx_mul(acc, x) + cstore[i]);
    return acc;
  endfunction

  // search bound max |a_i/a0| + 1
  function automatic longint bound_of(longint c[MaxDeg+1], int unsigned d);
    longint lim, r;
    lim = QOne;
    for (int i = 0; i <= d; i++) begin
      r = fx_div(c[i], c[0]);
      r = sat(r < 0 ? -r : r);
      if (r > lim) lim = r;
    end
    return sat(lim + QOne);
  endfunction

  function automatic longint secant_root(longint x0, longint x1, longint tol,
                                         output psrf_pkg::status_t st);
    longint xp, xc, f0, f1, q, nx;
    int unsigned it;
    xp = x0;
    xc = x1;
    it = 0;
    forever begin
      if (it >= MaxIter) begin
        st = psrf_pkg::ST_ITER_LIMIT;
        return xc;
      end
      f0 = poly_at(xp);
      f1 = poly_at(xc);
      if (f0 == f1) begin
        st = psrf_pkg::ST_ZERO_DEN;
        return xc;
      end
      q  = fx_div(f1, sat(f1 - f0));
      nx = sat(xc - fx_mul(q, sat(xc - xp)));
      it++;
      xp = xc;
      xc = nx;
      if (magn(xc - xp) < tol && magn(poly_at(xc)) < tol) begin
        st = psrf_pkg::ST_CONVERGED;
        return xc;
      end
    end
  endfunction

  // full scan once a polynomial is loaded
  task automatic predict_search();
    root_rec_t         rec;
    longint            lim, step, tol, left, right, fl, fr, x;
    int unsigned       pts, found;
    psrf_pkg::status_t st;
    found = 0;
    if (cstore[0] != 0) begin
      lim   = bound_of(cstore, eff_deg);
      step  = (step_reg == 0) ? 1 : longint'(step_reg);
      tol   = longint'(tol_reg);
      left  = -lim;
      right = left + step;
      pts   = 0;
      while (right <= lim && pts < psrf_pkg::MaxScanPoints && found < eff_deg) begin
        pts++;
        fl = poly_at(left);
        fr = poly_at(right);
        if ((fl < 0 && fr > 0) || (fl > 0 && fr < 0)) begin
          x = secant_root(left, right, tol, st);
          found++;
          rec.root = x[31:0];
          rec.num  = found[3:0];
          rec.st   = st;
          rec.last = 1'b0;
          root_q.push_back(rec);
          left  = sat(x + step);
          right = left + step;
        end else begin
          right += step;
        end
      end
    end
    rec.root = '0;
    rec.num  = found[3:0];
    rec.st   = psrf_pkg::ST_SCAN_DONE;
    rec.last = 1'b1;
    root_q.push_back(rec);
  endtask

  task automatic load_coef(logic [31:0] raw);
    eff_deg = deg_reg;
    if (eff_deg < 1) eff_deg = 1;
    if (eff_deg > MaxDeg) eff_deg = MaxDeg;
    if (load_cnt <= MaxDeg) cstore[load_cnt] = longint'(signed'(raw));
    load_cnt++;
    if (load_cnt >= eff_deg + 1) begin
      load_cnt = 0;
      predict_search();
    end
  endtask

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    fail_cnt++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // ---------------------------------------------------------------- driver
  // a held item stays valid until its transfer; the predictor sees each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) load_coef(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (coef_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= coef_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    root_rec_t want;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
      if (idle_cnt >= IdleLimit) begin
        $display("watchdog expired");
        $display("== FAIL ==");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (root_q.size() == 0) begin
          report("unexpected result", m_axis_tdata, '0);
        end else begin
          want = root_q.pop_front();
          if (m_axis_tdata[31:0] !== want.root) report("root_value", m_axis_tdata[31:0], want.root);
          if (m_axis_tdata[35:32] !== want.num) report("root_number", m_axis_tdata[35:32], want.num);
          if (m_axis_tuser !== want.st) report("status", m_axis_tuser, want.st);
          if (m_axis_tlast !== want.last) report("last_result", m_axis_tlast, want.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic cfg_write(psrf_pkg::cfg_idx_t idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      psrf_pkg::CFG_DEGREE:    deg_reg  = data[3:0];
      psrf_pkg::CFG_SCAN_STEP: step_reg = data[30:0];
      psrf_pkg::CFG_TOLERANCE: tol_reg  = data[30:0];
      default: ;
    endcase
  endtask

  // wait until every item went out and every root came back, then settle
  task automatic wait_quiet();
    int calm;
    calm = 0;
    while (calm < 4) begin
      @(posedge clk_i);
      if (coef_q.size() == 0 && !s_axis_tvalid && root_q.size() == 0) calm++;
      else calm = 0;
    end
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    longint      c[MaxDeg+1];
    longint      p[MaxDeg+1];
    longint      r, lim;
    int unsigned d, eff, raw_deg;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // x^2 - 1 under reset registers
    coef_q = '{32'h0001_0000, 32'h0, 32'hFFFF_0000};
    wait_quiet();
    // zero leading coefficient: completion only
    coef_q = '{32'h0, 32'h0005_0000, 32'h0007_0000};
    wait_quiet();
    // coefficient extremes
    cfg_write(psrf_pkg::CFG_DEGREE, 32'd1);
    coef_q = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    wait_quiet();
    // widest step and loosest tolerance, full degree, unused index
    cfg_write(psrf_pkg::CFG_DEGREE, 32'd8);
    cfg_write(psrf_pkg::CFG_SCAN_STEP, 32'h7FFF_FFFF);
    cfg_write(psrf_pkg::CFG_TOLERANCE, 32'hFFFF_FFFF);
    cfg_write(psrf_pkg::cfg_idx_t'(3), 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++) coef_q.push_back($urandom());
    wait_quiet();
    // degree lowered mid-load, and zero tolerance that can never converge
    coef_q = '{32'h0001_0000, 32'h0, 32'h1234_5678};
    wait_quiet();
    cfg_write(psrf_pkg::CFG_DEGREE, 32'd1);
    cfg_write(psrf_pkg::CFG_SCAN_STEP, 32'd29491);
    cfg_write(psrf_pkg::CFG_TOLERANCE, 32'd0);
    coef_q = '{32'h0003_0000};
    wait_quiet();
    // zero step acts as one lsb; x + 2 keeps the scan short
    cfg_write(psrf_pkg::CFG_TOLERANCE, 32'd66);
    cfg_write(psrf_pkg::CFG_SCAN_STEP, 32'd0);
    cfg_write(psrf_pkg::CFG_DEGREE, 32'd0);
    coef_q = '{32'h0001_0000, 32'h0002_0000};
    wait_quiet();

    // random polynomials; mostly built from integer roots
    for (int n = 0; n < 90; n++) begin
      case ((n / 12) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      foreach (c[i]) c[i] = 0;
      if ($urandom_range(0, 99) < 70) begin
        d = $urandom_range(1, 4);
        raw_deg = (d == 1 && $urandom_range(0, 3) == 0) ? 0 : d;
        foreach (p[i]) p[i] = 0;
        p[0] = $urandom_range(1, 3);
        if ($urandom_range(0, 1)) p[0] = -p[0];
        for (int k = 1; k <= d; k++) begin
          r = longint'($urandom_range(0, 8)) - 4;
          for (int i = k; i >= 1; i--) p[i] = p[i] - r * p[i-1];
        end
        for (int i = 0; i <= d; i++) c[i] = sat(p[i] * QOne);
      end else begin
        case ($urandom_range(0, 5))
          0: raw_deg = 0;
          1: raw_deg = 15;
          2: raw_deg = 8;
          default: raw_deg = $urandom_range(1, 5);
        endcase
        d = raw_deg < 1 ? 1 : (raw_deg > MaxDeg ? MaxDeg : raw_deg);
        for (int i = 0; i <= d; i++) c[i] = longint'(signed'(32'($urandom())));
        if ($urandom_range(0, 19) == 0) c[0] = 0;
      end
      eff = raw_deg < 1 ? 1 : (raw_deg > MaxDeg ? MaxDeg : raw_deg);
      cfg_write(psrf_pkg::CFG_DEGREE, 32'(raw_deg));
      // scale the step so the span from bound to bound is 4 to 24 steps
      if (c[0] != 0) begin
        lim = bound_of(c, eff);
        r = (2 * lim) / $urandom_range(4, 24);
        cfg_write(psrf_pkg::CFG_SCAN_STEP, 32'(r < 1 ? 1 : r));
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: cfg_write(psrf_pkg::CFG_TOLERANCE, 32'd66);
          1: cfg_write(psrf_pkg::CFG_TOLERANCE, $urandom_range(1, 4000));
          default: cfg_write(psrf_pkg::CFG_TOLERANCE, $urandom_range(4000, 32'h7FFF_FFFF));
        endcase
      end
      for (int i = 0; i <= eff; i++) coef_q.push_back(c[i][31:0]);
      // every poly ends in idle, so the sender also waits out all roots here
      wait_quiet();
    end

    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && root_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/psrf_pkg.sv
hdl/psrf_mul.sv
hdl/psrf_div.sv
hdl/polynomial_secant_root_finder.sv
dv/tb_polynomial_secant_root_finder.sv
